// File: rtl/hcd_pkg.sv
// shared types and constants of the histogram scene cut detector
package hcd_pkg;

  localparam int COLOR_W   = 8;
  localparam int BIN_W     = 12;
  localparam int BIN_COUNT = 4096;
  localparam int DIFF_W    = 25;
  localparam int FRAME_W   = 24;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  localparam logic [DIFF_W-1:0]  DIFF_MAX     = '1;
  localparam logic [FRAME_W-1:0] FRAME_MAX    = '1;
  localparam logic [DIFF_W-1:0]  THRESH_RESET = 25'd207360;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             frame_end;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// File: rtl/histogram_scene_cut_detector_top.sv
// top level of the histogram scene cut detector
// each pixel is a read-modify-write of one bin in the bank memory; the next request is popped
// only after the write; a frame-end pixel then sweeps 4096 bins, one bin per cycle through both banks
// result: after the sweep a drain state, then the result register loads once the output is not stalled
// reset: async active low; then a clearing pass over all 4096 bins of both banks, no pixels taken
// the threshold register resets to 207360; the user must write it only with no request in flight, unenforced
module histogram_scene_cut_detector_top #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          frame_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [23:0]                   frame_number_o,
  output logic [24:0]                   difference_o,
  output logic                          scene_cut_o,
  // threshold register
  input  logic                          cfg_we_i,
  input  logic [24:0]                   cfg_wdata_i
);

  // cut threshold register
  logic [hcd_pkg::DIFF_W-1:0] threshold_q;

  // front to back queue and status
  logic                       q_valid;
  logic                       q_pop;
  hcd_pkg::q_entry_t          q_entry;
  hcd_pkg::back_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= hcd_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // front: bin index and request queue
  hcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .frame_end_i (frame_end_i),
    .status_i    (status),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_entry_o   (q_entry)
  );

  // back: banks, sweep and result register
  hcd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_entry_i      (q_entry),
    .status_o       (status),
    .threshold_i    (threshold_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_number_o (frame_number_o),
    .difference_o   (difference_o),
    .scene_cut_o    (scene_cut_o)
  );

endmodule

// File: rtl/hcd_front.sv
// front end: bin index from the pixel colour and a short request queue
module hcd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hcd_pkg::COLOR_W-1:0]   red_i,
  input  logic [hcd_pkg::COLOR_W-1:0]   green_i,
  input  logic [hcd_pkg::COLOR_W-1:0]   blue_i,
  input  logic                          frame_end_i,
  input  hcd_pkg::back_status_t         status_i,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output hcd_pkg::q_entry_t             q_entry_o
);

  hcd_pkg::q_entry_t             q_mem_q [hcd_pkg::QDEPTH];
  logic [hcd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [hcd_pkg::QPTR_W:0]      count_q, count_d;
  logic                          push;
  logic                          full;
  hcd_pkg::q_entry_t             entry;

  assign full       = (count_q == (hcd_pkg::QPTR_W+1)'(hcd_pkg::QDEPTH));
  assign in_stall_o = full | status_i.clearing;
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = q_mem_q[rd_ptr_q];

  // red, green, blue high nibbles form the bin index
  assign entry.bin       = {red_i[7:4], green_i[7:4], blue_i[7:4]};
  assign entry.frame_end = frame_end_i;

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// File: rtl/hcd_back.sv
// back end: histogram banks, bin update, difference sweep and result register
module hcd_back #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  hcd_pkg::q_entry_t             q_entry_i,
  output hcd_pkg::back_status_t         status_o,
  input  logic [hcd_pkg::DIFF_W-1:0]    threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hcd_pkg::FRAME_W-1:0]   frame_number_o,
  output logic [hcd_pkg::DIFF_W-1:0]    difference_o,
  output logic                          scene_cut_o
);

  localparam int SUM_W = ((COUNT_WIDTH > hcd_pkg::DIFF_W) ? COUNT_WIDTH : hcd_pkg::DIFF_W) + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [hcd_pkg::BIN_W-1:0]      idx_q, idx_d;
  logic [hcd_pkg::BIN_W-1:0]      bin_q;
  logic                           fe_q;
  logic                           cur_q;
  logic                           rdv_q;
  logic [hcd_pkg::FRAME_W-1:0]    frames_q;
  logic [hcd_pkg::DIFF_W-1:0]     acc_q, acc_d;
  logic                           out_valid_q;
  logic [hcd_pkg::FRAME_W-1:0]    frame_number_q;
  logic [hcd_pkg::DIFF_W-1:0]     difference_q;
  logic                           scene_cut_q;

  logic [COUNT_WIDTH-1:0]         mem_a [hcd_pkg::BIN_COUNT];
  logic [COUNT_WIDTH-1:0]         mem_b [hcd_pkg::BIN_COUNT];
  logic [COUNT_WIDTH-1:0]         rd_a_q, rd_b_q;

  logic [hcd_pkg::BIN_W-1:0]      rd_addr, wr_addr;
  logic                           wr_a, wr_b;
  logic [COUNT_WIDTH-1:0]         wr_data;
  logic [COUNT_WIDTH-1:0]         cur_rd, prev_rd, inc, diff;
  logic [SUM_W-1:0]               sum;
  logic [hcd_pkg::DIFF_W-1:0]     acc_sat;
  logic                           load_out;

  assign cur_rd  = cur_q ? rd_b_q : rd_a_q;
  assign prev_rd = cur_q ? rd_a_q : rd_b_q;
  assign inc     = (cur_rd == '1) ? cur_rd : cur_rd + 1'b1;
  assign diff    = (cur_rd >= prev_rd) ? cur_rd - prev_rd : prev_rd - cur_rd;
  assign sum     = SUM_W'(acc_q) + SUM_W'(diff);
  assign acc_sat = (sum > SUM_W'(hcd_pkg::DIFF_MAX)) ? hcd_pkg::DIFF_MAX
                                                    : sum[hcd_pkg::DIFF_W-1:0];

  assign load_out          = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign q_pop_o           = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    rd_addr = idx_q;
    wr_addr = idx_q;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    wr_data = '0;
    case (state_q)
      ST_CLEAR: begin
        wr_a  = 1'b1;
        wr_b  = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = q_entry_i.bin;
        if (q_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        wr_addr = bin_q;
        wr_data = inc;
        wr_a    = ~cur_q;
        wr_b    = cur_q;
        if (fe_q) begin
          state_d = ST_SWEEP;
          idx_d   = '0;
          acc_d   = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // read both banks, wipe the previous bank behind the read
        wr_a  = cur_q;
        wr_b  = ~cur_q;
        idx_d = idx_q + 1'b1;
        if (rdv_q) begin
          acc_d = acc_sat;
        end
        if (idx_q == '1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        acc_d   = acc_sat;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      cur_q       <= 1'b0;
      rdv_q       <= 1'b0;
      frames_q    <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      rdv_q   <= (state_q == ST_SWEEP);
      if (load_out) begin
        out_valid_q <= 1'b1;
        cur_q       <= ~cur_q;
        if (frames_q != hcd_pkg::FRAME_MAX) begin
          frames_q <= frames_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bin_q <= q_entry_i.bin;
      fe_q  <= q_entry_i.frame_end;
    end
    if (load_out) begin
      frame_number_q <= frames_q;
      difference_q   <= acc_q;
      scene_cut_q    <= (frames_q != '0) && (acc_q >= threshold_i);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_a[rd_addr];
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_b_q <= mem_b[rd_addr];
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = frame_number_q;
  assign difference_o   = difference_q;
  assign scene_cut_o    = scene_cut_q;

endmodule

// File: rtl/hcd_checker.sv
// port checker of the histogram scene cut detector and its bind
module hcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] frame_number_o,
  input logic [24:0] difference_o,
  input logic        scene_cut_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(difference_o) && $stable(frame_number_o))
    else $error("stalled result changed");

  a_first_no_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_number_o == 24'd0 |-> !scene_cut_o)
    else $error("cut flagged on first frame");

  a_frame_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && frame_number_o != 24'hFFFFFF
      |-> frame_number_o != $past(frame_number_o))
    else $error("frame number repeated");

endmodule

bind histogram_scene_cut_detector_top hcd_checker u_hcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_number_o (frame_number_o),
  .difference_o   (difference_o),
  .scene_cut_o    (scene_cut_o)
);
